// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the Erlang variate generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== design/evg_pkg.sv =====
// ----------------------------------------------------------------------------
// evg_pkg
// Types and constants of the Erlang variate generator.
// ----------------------------------------------------------------------------
package evg_pkg;

   localparam int MULT_REGS = 5;
   localparam int LOG_STEPS = 56;
   localparam int REM_BITS  = 64;

   localparam logic [2:0]  CSR_MODULUS   = 3'd5;
   localparam logic [30:0] MODULUS_RESET = 31'd2147483647;
   localparam logic [28:0] OUT_MAX       = 29'h1FFF_FFFF;
   // round(0.2 * ln 2 * 2^64)
   localparam logic [63:0] LN2_FIFTH     = 64'h237D_37FE_5D29_7EBC;

   localparam logic [30:0] MULT_RESET [MULT_REGS] =
      '{31'd71807, 31'd54807, 31'd91807, 31'd81807, 31'd83807};
   localparam logic [30:0] SEED_RESET [MULT_REGS] =
      '{31'd4111, 31'd7113, 31'd7991, 31'd8111, 31'd9999};

   typedef enum logic [1:0] {REM_SEED, REM_STATE, REM_PROD} rem_sel_type;
   typedef enum logic {LOG_OF_M, LOG_OF_N} log_sel_type;
   typedef enum logic {MUL_DC, MUL_AX} mul_sel_type;
   typedef enum logic [1:0] {LOG_IDLE, LOG_NORM, LOG_SQUARE} log_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_LOAD_REM, ST_LOG_M, ST_X_REM, ST_N_LOG,
      ST_D_MUL, ST_AX_MUL, ST_AX_REM, ST_NEXT, ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic        req_take;
      logic        rem_start;
      rem_sel_type rem_sel;
      logic        log_start;
      log_sel_type log_sel;
      logic        logm_capture;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        load_write;
      logic        state_write;
      logic        sum_clear;
      logic        sum_add;
      logic        stream_next;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic rem_done;
      logic log_done;
      logic mul_done;
      logic last_stream;
      logic op_draw;
      logic rsp_full;
   } status_type;

endpackage

// ===== design/evg_mul.sv =====
// ----------------------------------------------------------------------------
// evg_mul
// 64x64 multiplier, one 32x32 partial product per cycle, four partial products in all.
// ----------------------------------------------------------------------------
module evg_mul (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   op_a,
   input  logic [63:0]   op_b,
   output logic          busy,
   output logic          done,
   output logic [127:0]  prod
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  pa, pb;
   logic [63:0]  pp;

   always_comb begin
      pa = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      pb = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = pa * pb;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = op_a;
         b_in = op_b;
         acc_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         unique case (cnt_ff)
            2'd0:    acc_in = acc_ff + {64'd0, pp};
            2'd3:    acc_in = acc_ff + {pp, 64'd0};
            default: acc_in = acc_ff + {32'd0, pp, 32'd0};
         endcase
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== design/evg_rem.sv =====
// ----------------------------------------------------------------------------
// evg_rem
// Restoring bit-serial remainder of a 64-bit dividend by a 31-bit modulus.
// ----------------------------------------------------------------------------
module evg_rem (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   dividend,
   input  logic [30:0]   divisor,
   output logic          busy,
   output logic          done,
   output logic [30:0]   remainder
);

   localparam int CntW = $clog2(evg_pkg::REM_BITS);

   logic [63:0]     dvd_ff, dvd_in;
   logic [31:0]     r_ff, r_in, trial;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      dvd_in = dvd_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[30:0], dvd_ff[63]};
      if (start) begin
         dvd_in = dividend;
         r_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         dvd_in = {dvd_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(evg_pkg::REM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      r_ff   <= r_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign remainder = r_ff[30:0];

endmodule

// ===== design/evg_log.sv =====
// ----------------------------------------------------------------------------
// evg_log
// log2 of a 31-bit integer as Q.56: serial normalize, then 56 square steps.
// ----------------------------------------------------------------------------
module evg_log (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [30:0]   k,
   output logic          done,
   output logic [60:0]   log_q
);

   evg_pkg::log_phase_type phase_ff, phase_in;
   logic [63:0]  y_ff, y_in, ysq;
   logic [4:0]   e_ff, e_in;
   logic [55:0]  frac_ff, frac_in;
   logic [5:0]   step_ff, step_in;
   logic         done_ff, done_in, mul_go, mul_busy, mul_done;
   logic [127:0] mul_prod;

   evg_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_go), .op_a(y_in), .op_b(y_in),
      .busy(mul_busy), .done(mul_done), .prod(mul_prod)
   );

   always_comb begin
      phase_in = phase_ff;
      y_in = y_ff;
      e_in = e_ff;
      frac_in = frac_ff;
      step_in = step_ff;
      done_in = 1'b0;
      mul_go = 1'b0;
      ysq = mul_prod[125:62];
      unique case (phase_ff)
         evg_pkg::LOG_IDLE: begin
            if (start) begin
               y_in = {1'b0, k, 32'd0};
               e_in = 5'd30;
               frac_in = '0;
               step_in = '0;
               phase_in = evg_pkg::LOG_NORM;
            end
         end
         evg_pkg::LOG_NORM: begin
            if (y_ff[62]) begin
               mul_go = 1'b1;
               phase_in = evg_pkg::LOG_SQUARE;
            end else begin
               y_in = {y_ff[62:0], 1'b0};
               e_in = e_ff - 5'd1;
            end
         end
         evg_pkg::LOG_SQUARE: begin
            if (mul_done) begin
               frac_in = {frac_ff[54:0], ysq[63]};
               y_in = ysq[63] ? {1'b0, ysq[63:1]} : ysq;
               if (step_ff == 6'(evg_pkg::LOG_STEPS - 1)) begin
                  done_in = 1'b1;
                  phase_in = evg_pkg::LOG_IDLE;
               end else begin
                  step_in = step_ff + 6'd1;
                  mul_go = 1'b1;
               end
            end
         end
         default: phase_in = evg_pkg::LOG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= evg_pkg::LOG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      y_ff    <= y_in;
      e_ff    <= e_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign log_q = {e_ff, frac_ff};

`include "assert_macros.svh"
   `ASSERT_IMPLIES(a_log_mul_idle, clock, reset, mul_go, !mul_busy)
   `ASSERT_IMPLIES(a_log_start_idle, clock, reset, start, phase_ff == evg_pkg::LOG_IDLE)

endmodule

// ===== design/evg_datapath.sv =====
// ----------------------------------------------------------------------------
// evg_datapath
// Registers, stream states and arithmetic units of the variate generator.
// ----------------------------------------------------------------------------
module evg_datapath #(
   parameter int STREAMS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  evg_pkg::cmd_type    cmd,
   output evg_pkg::status_type status,
   input  logic                req_op,
   input  logic [2:0]          req_stream_index,
   input  logic [30:0]         req_seed_value,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [30:0]         csr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [28:0]         rsp_erlang_value
);

   localparam int IdxW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

   logic [30:0] mult_ff [evg_pkg::MULT_REGS];
   logic [30:0] modulus_ff, m_eff;
   logic [30:0] state_ff [STREAMS];
   logic        op_ff;
   logic [2:0]  idx_ff;
   logic [30:0] seed_ff;
   logic [IdxW-1:0] sc_ff;
   logic [2:0]  mi_ff;
   logic [60:0] logm_ff, d;
   logic [31:0] sum_ff, term;
   logic        rsp_valid_ff;
   logic [28:0] rsp_data_ff;

   logic [63:0]  rem_dvd, mul_a, mul_b;
   logic [30:0]  rem_r, log_k;
   logic         rem_busy, rem_done, log_done, mul_busy, mul_done;
   logic [60:0]  log_q;
   logic [127:0] mul_prod;

   assign m_eff = (modulus_ff < 31'd2) ? 31'd2 : modulus_ff;

   always_comb begin
      unique case (cmd.rem_sel)
         evg_pkg::REM_SEED:  rem_dvd = {33'd0, seed_ff};
         evg_pkg::REM_STATE: rem_dvd = {33'd0, state_ff[sc_ff]};
         evg_pkg::REM_PROD:  rem_dvd = mul_prod[63:0];
         default:            rem_dvd = '0;
      endcase
      log_k = (cmd.log_sel == evg_pkg::LOG_OF_M) ? m_eff : m_eff - rem_r;
      d = (logm_ff > log_q) ? logm_ff - log_q : '0;
      if (cmd.mul_sel == evg_pkg::MUL_DC) begin
         mul_a = {3'd0, d};
         mul_b = evg_pkg::LN2_FIFTH;
      end else begin
         mul_a = {33'd0, mult_ff[mi_ff]};
         mul_b = {33'd0, rem_r};
      end
      // round half up to 2^-24
      term = mul_prod[127:96] + {31'd0, mul_prod[95]};
   end

   evg_rem u_rem (
      .clock(clock), .reset(reset), .start(cmd.rem_start), .dividend(rem_dvd),
      .divisor(m_eff), .busy(rem_busy), .done(rem_done), .remainder(rem_r)
   );

   evg_log u_log (
      .clock(clock), .reset(reset), .start(cmd.log_start), .k(log_k),
      .done(log_done), .log_q(log_q)
   );

   evg_mul u_mul (
      .clock(clock), .reset(reset), .start(cmd.mul_start), .op_a(mul_a), .op_b(mul_b),
      .busy(mul_busy), .done(mul_done), .prod(mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < evg_pkg::MULT_REGS; i++) begin
            mult_ff[i] <= evg_pkg::MULT_RESET[i];
         end
         modulus_ff <= evg_pkg::MODULUS_RESET;
         for (int i = 0; i < STREAMS; i++) begin
            state_ff[i] <= evg_pkg::SEED_RESET[i % evg_pkg::MULT_REGS];
         end
         rsp_valid_ff <= 1'b0;
         sc_ff <= '0;
         mi_ff <= '0;
      end else begin
         if (csr_write) begin
            if (32'(csr_index) < evg_pkg::MULT_REGS) begin
               mult_ff[csr_index] <= csr_data;
            end else if (csr_index == evg_pkg::CSR_MODULUS) begin
               modulus_ff <= csr_data;
            end
         end
         if (cmd.load_write && (32'(idx_ff) < STREAMS)) begin
            state_ff[idx_ff[IdxW-1:0]] <= rem_r;
         end
         if (cmd.state_write) begin
            state_ff[sc_ff] <= rem_r;
         end
         if (cmd.sum_clear) begin
            sc_ff <= '0;
            mi_ff <= '0;
         end else if (cmd.stream_next) begin
            sc_ff <= sc_ff + 1'b1;
            mi_ff <= (32'(mi_ff) == evg_pkg::MULT_REGS - 1) ? 3'd0 : mi_ff + 3'd1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.req_take) begin
         op_ff <= req_op;
         idx_ff <= req_stream_index;
         seed_ff <= req_seed_value;
      end
      if (cmd.logm_capture) begin
         logm_ff <= log_q;
      end
      if (cmd.sum_clear) begin
         sum_ff <= '0;
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + term;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= (sum_ff > {3'd0, evg_pkg::OUT_MAX}) ? evg_pkg::OUT_MAX
                                                            : sum_ff[28:0];
      end
   end

   assign status.rem_done = rem_done;
   assign status.log_done = log_done;
   assign status.mul_done = mul_done;
   assign status.last_stream = (32'(sc_ff) == STREAMS - 1);
   assign status.op_draw = op_ff;
   assign status.rsp_full = rsp_valid_ff && !rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_erlang_value = rsp_data_ff;

`include "assert_macros.svh"
   `ASSERT_IMPLIES(a_rem_idle, clock, reset, cmd.rem_start, !rem_busy)
   `ASSERT_IMPLIES(a_mul_idle, clock, reset, cmd.mul_start, !mul_busy)
   `ASSERT_NEXT(a_rsp_set, clock, reset, cmd.rsp_load, rsp_valid_ff)

endmodule

// ===== design/evg_ctrl.sv =====
// ----------------------------------------------------------------------------
// evg_ctrl
// Sequencer: issues load and draw steps to the datapath units.
// ----------------------------------------------------------------------------
module evg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  evg_pkg::status_type status,
   output evg_pkg::cmd_type    cmd
);

   evg_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= evg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rem_sel = evg_pkg::REM_STATE;
      cmd.log_sel = evg_pkg::LOG_OF_N;
      cmd.mul_sel = evg_pkg::MUL_DC;
      req_ready = 1'b0;
      unique case (state_ff)
         evg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_take = 1'b1;
               state_in = evg_pkg::ST_DECODE;
            end
         end
         evg_pkg::ST_DECODE: begin
            if (status.op_draw) begin
               cmd.log_start = 1'b1;
               cmd.log_sel = evg_pkg::LOG_OF_M;
               cmd.sum_clear = 1'b1;
               state_in = evg_pkg::ST_LOG_M;
            end else begin
               cmd.rem_start = 1'b1;
               cmd.rem_sel = evg_pkg::REM_SEED;
               state_in = evg_pkg::ST_LOAD_REM;
            end
         end
         evg_pkg::ST_LOAD_REM: begin
            if (status.rem_done) begin
               cmd.load_write = 1'b1;
               state_in = evg_pkg::ST_IDLE;
            end
         end
         evg_pkg::ST_LOG_M: begin
            if (status.log_done) begin
               cmd.logm_capture = 1'b1;
               cmd.rem_start = 1'b1;
               state_in = evg_pkg::ST_X_REM;
            end
         end
         evg_pkg::ST_X_REM: begin
            // n = m - x is taken from the remainder result
            if (status.rem_done) begin
               cmd.log_start = 1'b1;
               state_in = evg_pkg::ST_N_LOG;
            end
         end
         evg_pkg::ST_N_LOG: begin
            if (status.log_done) begin
               cmd.mul_start = 1'b1;
               state_in = evg_pkg::ST_D_MUL;
            end
         end
         evg_pkg::ST_D_MUL: begin
            if (status.mul_done) begin
               cmd.sum_add = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_sel = evg_pkg::MUL_AX;
               state_in = evg_pkg::ST_AX_MUL;
            end
         end
         evg_pkg::ST_AX_MUL: begin
            if (status.mul_done) begin
               cmd.rem_start = 1'b1;
               cmd.rem_sel = evg_pkg::REM_PROD;
               state_in = evg_pkg::ST_AX_REM;
            end
         end
         evg_pkg::ST_AX_REM: begin
            if (status.rem_done) begin
               cmd.state_write = 1'b1;
               if (status.last_stream) begin
                  state_in = evg_pkg::ST_OUT;
               end else begin
                  cmd.stream_next = 1'b1;
                  state_in = evg_pkg::ST_NEXT;
               end
            end
         end
         evg_pkg::ST_NEXT: begin
            cmd.rem_start = 1'b1;
            state_in = evg_pkg::ST_X_REM;
         end
         evg_pkg::ST_OUT: begin
            if (!status.rsp_full) begin
               cmd.rsp_load = 1'b1;
               state_in = evg_pkg::ST_IDLE;
            end
         end
         default: state_in = evg_pkg::ST_IDLE;
      endcase
   end

`include "assert_macros.svh"
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.rsp_load, !status.rsp_full)
   `ASSERT_NEXT(a_take_decode, clock, reset, req_valid && req_ready,
                state_ff == evg_pkg::ST_DECODE)

endmodule

// ===== design/erlang_variate_generator_top.sv =====
// Load transaction: the seed is reduced by the serial remainder unit, then the
// next request is accepted. Draw transaction: its length grows with STREAMS and
// the leading zeros of the 31-bit m and each m - x; set by the 56-step log unit and
// the 64-bit remainder unit. One transaction at a time; a result waits in the
// output register while the next runs, and stalls a draw only if still unread.
// Synchronous active-high reset restores multipliers, modulus and stream seeds.
// ----------------------------------------------------------------------------
// erlang_variate_generator_top
// Erlang(5, rate 5) variates from Lehmer generator streams.
// ----------------------------------------------------------------------------
module erlang_variate_generator_top #(
   parameter int STREAMS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [2:0]  req_stream_index,
   input  logic [30:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [28:0] rsp_erlang_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_data
);

   evg_pkg::cmd_type    cmd;
   evg_pkg::status_type status;

   assign csr_ready = 1'b1;

   evg_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .status(status), .cmd(cmd)
   );

   evg_datapath #(.STREAMS(STREAMS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_op(req_op), .req_stream_index(req_stream_index),
      .req_seed_value(req_seed_value),
      .csr_write(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_erlang_value(rsp_erlang_value)
   );

endmodule

// ===== tb/erlang_variate_generator_top_test.sv =====
// ----------------------------------------------------------------------------
// erlang_variate_generator_top_test
// Self-checking bench: drives CSR writes, load and draw transactions and checks every
// erlang_value against a built-in predictor of the five Lehmer streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erlang_variate_generator_top_test;

   localparam int NSTREAM     = 5;
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DRAW   = 1'b1;
   localparam logic [2:0] CSR_MULT_0    = 3'd0;
   localparam logic [2:0] CSR_MULT_1    = 3'd1;
   localparam logic [2:0] CSR_MULT_2    = 3'd2;
   localparam logic [2:0] CSR_MULT_3    = 3'd3;
   localparam logic [2:0] CSR_MULT_4    = 3'd4;
   localparam logic [2:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [2:0] CSR_UNUSED_HI = 3'd7;
   localparam int DRAW_CYCLES = 320 + 460 * NSTREAM;
   localparam int SETTLE      = DRAW_CYCLES + 200;
   localparam longint CYCLE_LIMIT = 64'd8_000_000;

   typedef struct packed {
      logic        op;
      logic [2:0]  stream_index;
      logic [30:0] seed_value;
   } item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [2:0]  req_stream_index = '0;
   logic [30:0] req_seed_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [28:0] rsp_erlang_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [30:0] csr_data = '0;

   erlang_variate_generator_top #(.STREAMS(NSTREAM)) dut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [30:0] mult_q [evg_pkg::MULT_REGS];
   logic [30:0] mod_q;
   logic [30:0] lehmer_q [NSTREAM];

   item_type    pending_q [$];
   logic [28:0] erlang_expected_q [$];
   int          errors = 0;
   int          draws_seen = 0;
   int          loads_sent = 0;
   longint      cycle_count = 0;
   bit          hold_sender = 1'b0;
   bit          req_fire = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;

   task automatic report(input string what, input logic [28:0] got, input logic [28:0] exp);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, exp, cycle_count);
      errors++;
   endtask

   function automatic logic [63:0] log2_q56(input logic [63:0] k);
      logic [63:0]  y;
      logic [127:0] sq;
      logic [63:0]  frac;
      int           e;
      frac = '0;
      e = 0;
      if (k == 0) return '0;
      while (e < 31 && (k >> (e + 1)) != 0) e++;
      y = k << (62 - e);
      for (int s = 0; s < 56; s++) begin
         sq = y * y;
         y = sq[125:62];
         frac = frac << 1;
         if (y[63]) begin
            frac[0] = 1'b1;
            y = y >> 1;
         end
      end
      return (64'(e) << 56) | frac;
   endfunction

   function automatic logic [63:0] eff_modulus();
      return (mod_q < 2) ? 64'd2 : 64'(mod_q);
   endfunction

   // advances the predictor; returns 1 and the value for a draw
   function automatic bit predict_item(input item_type it, output logic [28:0] value);
      logic [63:0]  m, lm, ln, d, x, sum;
      logic [127:0] prod;
      m = eff_modulus();
      value = '0;
      if (it.op == OP_LOAD) begin
         if (it.stream_index < NSTREAM)
            lehmer_q[it.stream_index] = 31'(64'(it.seed_value) % m);
         return 1'b0;
      end
      lm = log2_q56(m);
      sum = '0;
      for (int i = 0; i < NSTREAM; i++) begin
         x = 64'(lehmer_q[i]) % m;
         ln = log2_q56(m - x);
         d = (lm > ln) ? lm - ln : 64'd0;
         prod = d * evg_pkg::LN2_FIFTH;
         sum += (prod[127:64] + 64'h8000_0000) >> 32;
         lehmer_q[i] = 31'((64'(mult_q[i % evg_pkg::MULT_REGS]) * x) % m);
      end
      value = (sum > 64'(evg_pkg::OUT_MAX)) ? evg_pkg::OUT_MAX : sum[28:0];
      return 1'b1;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            // previous transaction taken at the last rising edge (or none): pick next
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (!hold_sender && pending_q.size() > 0) begin
               item_type it;
               logic [28:0] v;
               it = pending_q.pop_front();
               if (predict_item(it, v)) erlang_expected_q.push_back(v);
               else loads_sent++;
               req_valid <= 1'b1;
               req_op <= it.op;
               req_stream_index <= it.stream_index;
               req_seed_value <= it.seed_value;
               if (burst_left > 0) burst_left <= burst_left - 1;
               else begin
                  burst_left <= $urandom_range(0, 6);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
               end
            end else
               req_valid <= 1'b0;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ((cycle_count % 97) > 60);
         endcase
         if (cycle_count % 3000 == 0) stall_mode <= $urandom_range(0, 2);
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_fire <= req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (erlang_expected_q.size() == 0)
            report("unexpected result", rsp_erlang_value, '0);
         else begin
            logic [28:0] e;
            e = erlang_expected_q.pop_front();
            if (rsp_erlang_value !== e) report("erlang_value", rsp_erlang_value, e);
            draws_seen++;
         end
      end
   end

   task automatic wait_drained();
      while (pending_q.size() > 0 || req_valid || erlang_expected_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [30:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx < evg_pkg::MULT_REGS) mult_q[idx] = val;
      else if (idx == evg_pkg::CSR_MODULUS) mod_q = val;
   endtask

   function automatic item_type mk(input logic op, input logic [2:0] s, input logic [30:0] v);
      item_type it;
      it.op = op;
      it.stream_index = s;
      it.seed_value = v;
      return it;
   endfunction

   task automatic queue_random(input int n, input int maxseed);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0)
            pending_q.push_back(mk(OP_LOAD, 3'($urandom_range(0, 7)),
               31'($urandom_range(0, maxseed))));
         else
            pending_q.push_back(mk(OP_DRAW, 3'($urandom), 31'($urandom)));
      end
   endtask

   initial begin
      for (int i = 0; i < evg_pkg::MULT_REGS; i++) mult_q[i] = evg_pkg::MULT_RESET[i];
      mod_q = evg_pkg::MODULUS_RESET;
      for (int i = 0; i < NSTREAM; i++) lehmer_q[i] = evg_pkg::SEED_RESET[i % evg_pkg::MULT_REGS];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset seeds, field extremes, zero state, bad index
      pending_q.push_back(mk(OP_DRAW, 3'd7, 31'h7FFF_FFFF));
      pending_q.push_back(mk(OP_DRAW, 3'd0, 31'd0));
      pending_q.push_back(mk(OP_LOAD, 3'd0, 31'd0));
      pending_q.push_back(mk(OP_LOAD, 3'd4, 31'd2147483646));
      pending_q.push_back(mk(OP_LOAD, 3'd5, 31'd1234));
      pending_q.push_back(mk(OP_LOAD, 3'd7, 31'h7FFF_FFFF));
      pending_q.push_back(mk(OP_LOAD, 3'd1, 31'h7FFF_FFFF));
      pending_q.push_back(mk(OP_DRAW, 3'd3, 31'h5555_5555));
      pending_q.push_back(mk(OP_LOAD, 3'd2, 31'd1));
      pending_q.push_back(mk(OP_LOAD, 3'd3, 31'h2AAA_AAAA));
      pending_q.push_back(mk(OP_DRAW, 3'd0, 31'd0));
      pending_q.push_back(mk(OP_DRAW, 3'd0, 31'd0));
      queue_random(180, 32'h7FFF_FFFE);
      // pause until all results are back
      while (pending_q.size() > 150) @(posedge clock);
      hold_sender = 1'b1;
      while (req_valid || erlang_expected_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      hold_sender = 1'b0;
      wait_drained();

      // extremes: zero and max multipliers, small modulus, stale states
      csr_write(CSR_MULT_0, 31'd0);
      csr_write(CSR_MULT_1, 31'd1);
      csr_write(CSR_MULT_2, 31'h7FFF_FFFE);
      csr_write(CSR_MULT_3, 31'd16807);
      csr_write(CSR_MULT_4, 31'h7FFF_FFFF);
      csr_write(evg_pkg::CSR_MODULUS, 31'd1000);
      csr_write(CSR_UNUSED_LO, 31'd99);
      csr_write(CSR_UNUSED_HI, 31'd5);
      queue_random(150, 2000);
      wait_drained();

      csr_write(evg_pkg::CSR_MODULUS, 31'd0);
      queue_random(30, 10);
      wait_drained();
      csr_write(evg_pkg::CSR_MODULUS, 31'd2);
      queue_random(30, 10);
      wait_drained();

      csr_write(CSR_MULT_0, 31'd48271);
      csr_write(CSR_MULT_4, 31'd1);
      csr_write(evg_pkg::CSR_MODULUS, 31'h7FFF_FFFF);
      queue_random(150, 32'h7FFF_FFFE);
      wait_drained();

      csr_write(evg_pkg::CSR_MODULUS, 31'($urandom_range(3, 32'h7FFF_FFFE)));
      for (int i = 0; i < evg_pkg::MULT_REGS; i++)
         csr_write(3'(i), 31'($urandom_range(1, 32'h7FFF_FFFE)));
      queue_random(160, 32'h7FFF_FFFE);
      wait_drained();

      $display("Covered %0d draws and %0d loads over several multiplier/modulus settings,",
         draws_seen, loads_sent);
      $display("including zero state, small and stale modulus, and out-of-range loads.");
      if (errors == 0)
         $display("erlang_variate_generator_top_test: PASS");
      else
         $display("erlang_variate_generator_top_test: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("erlang_variate_generator_top_test: FAIL");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/evg_pkg.sv
design/evg_mul.sv
design/evg_rem.sv
design/evg_log.sv
design/evg_datapath.sv
design/evg_ctrl.sv
design/erlang_variate_generator_top.sv
tb/erlang_variate_generator_top_test.sv
